FILE: rtl/core/chte_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// chte_pkg
// shared constants and request/status codes of the chained hash table engine
// ---------------------------------------------------------------------------
package chte_pkg;

    localparam int POOL_ENTRIES_DEF    = 256;
    localparam int MAX_BUCKETS_DEF     = 256;
    localparam int MAX_KEY_BYTES_DEF   = 8;
    localparam int MAX_VALUE_BYTES_DEF = 8;

    localparam logic [63:0] HASH_SEED = 64'd5381;
    localparam int          HASH_SHIFT = 5;

    localparam logic [1:0] REQ_INSERT   = 2'd0;
    localparam logic [1:0] REQ_GET      = 2'd1;
    localparam logic [1:0] REQ_REMOVE   = 2'd2;
    localparam logic [1:0] REQ_CONTAINS = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    localparam logic [1:0] REG_BUCKETS  = 2'd0;
    localparam logic [1:0] REG_KEY_LEN  = 2'd1;
    localparam logic [1:0] REG_VAL_LEN  = 2'd2;

    // mask of the low n bytes, n already clamped to 1..8
    function automatic logic [63:0] byte_mask(input logic [3:0] n);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (4'(i) < n)
            begin
                m[8*i +: 8] = 8'hff;
            end
        end
        return m;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/chte_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// chte_ram
// single port synchronous ram, one write or read per cycle, registered read
// ---------------------------------------------------------------------------
module chte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

FILE: rtl/core/chained_hash_table_engine_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// chained_hash_table_engine_unit
// djb2 hashed key/value table, separate chaining through a fixed entry pool
// ---------------------------------------------------------------------------
//  channel | signals                                          | dir
//  req     | req_valid req_stall req_type lookup_key data_value| in
//  rsp     | rsp_valid rsp_stall status found value_out       | out
//          | entry_total                                      |
//  cfg     | psel penable pwrite paddr pwdata prdata pready   | in/out
//
// one request at a time: hash one key byte per cycle (up to 8), modulo by
// repeated compare-subtract over 9 bits (hash bits fed one per cycle), then
// one head read and an entry read and key compare per chain entry visited,
// a lowest-free search of one slot per cycle on inserts of new keys, and a
// final table write. after reset a clearing pass empties every bucket head;
// no request is taken during it. results wait in an output register; the
// next request is taken once the result beat has left.
// ---------------------------------------------------------------------------
module chained_hash_table_engine_unit
#(
    parameter int POOL_ENTRIES = chte_pkg::POOL_ENTRIES_DEF,
    parameter int MAX_BUCKETS  = chte_pkg::MAX_BUCKETS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire logic [1:0]  req_type,
    input  wire logic [63:0] lookup_key,
    input  wire logic [63:0] data_value,
    output logic             rsp_valid,
    input  wire logic        rsp_stall,
    output logic [1:0]       status,
    output logic             found,
    output logic [63:0]      value_out,
    output logic [8:0]       entry_total,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import chte_pkg::*;

    localparam int PW = $clog2(POOL_ENTRIES);
    localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int CW = PW + 1;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_HASH, S_MOD, S_HEAD, S_HEADW, S_ENT, S_ENTW,
        S_FREE, S_FREEW, S_WRITE, S_WRITE2, S_DONE
    } state_t;

    state_t state_reg;

    // configuration
    logic [8:0] nbuck_reg;
    logic [3:0] nkey_reg;
    logic [3:0] nval_reg;
    logic [8:0] nb_c;
    logic [3:0] nk_c;
    logic [3:0] nv_c;

    always_comb
    begin
        nb_c = (nbuck_reg == 9'd0) ? 9'd1 : nbuck_reg;
        if ({23'd0, nb_c} > MAX_BUCKETS) nb_c = 9'(MAX_BUCKETS);
        nk_c = (nkey_reg == 4'd0) ? 4'd1 : ((nkey_reg > 4'd8) ? 4'd8 : nkey_reg);
        nv_c = (nval_reg == 4'd0) ? 4'd1 : ((nval_reg > 4'd8) ? 4'd8 : nval_reg);
    end

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_BUCKETS: prdata = {23'd0, nbuck_reg};
            REG_KEY_LEN: prdata = {28'd0, nkey_reg};
            REG_VAL_LEN: prdata = {28'd0, nval_reg};
            default:     prdata = '0;
        endcase
    end

    // memories: bucket heads {valid, index}, entries {key, value}, links {valid, index}
    logic          hd_we;
    logic [BW-1:0] hd_addr;
    logic [PW:0]   hd_wdata;
    logic [PW:0]   hd_rdata;
    logic          en_we;
    logic [PW-1:0] en_addr;
    logic [127:0]  en_wdata;
    logic [127:0]  en_rdata;
    logic          ln_we;
    logic [PW:0]   ln_wdata;
    logic [PW:0]   ln_rdata;

    chte_ram #(.WIDTH(PW + 1), .DEPTH(MAX_BUCKETS)) u_heads (
        .clk(clk), .we(hd_we), .addr(hd_addr), .wdata(hd_wdata), .rdata(hd_rdata)
    );
    chte_ram #(.WIDTH(128), .DEPTH(POOL_ENTRIES)) u_entries (
        .clk(clk), .we(en_we), .addr(en_addr), .wdata(en_wdata), .rdata(en_rdata)
    );
    chte_ram #(.WIDTH(PW + 1), .DEPTH(POOL_ENTRIES)) u_links (
        .clk(clk), .we(ln_we), .addr(en_addr), .wdata(ln_wdata), .rdata(ln_rdata)
    );

    // free slots are flip-flops, searched one slot per cycle
    logic [POOL_ENTRIES-1:0] free_reg;

    logic [1:0]    req_reg;
    logic [63:0]   key_reg;
    logic [63:0]   data_reg;
    logic [63:0]   hash_reg;
    logic [3:0]    cnt_reg;
    logic [6:0]    bit_reg;
    logic [8:0]    rem_reg;
    logic [BW-1:0] bkt_reg;
    logic [PW-1:0] cur_reg;
    logic [PW-1:0] prev_reg;
    logic          have_prev_reg;
    logic [PW:0]   head_reg;
    logic [PW:0]   succ_reg;
    logic [PW-1:0] slot_reg;
    logic [CW-1:0] steps_reg;
    logic [BW:0]   clr_reg;
    logic [8:0]    live_reg;
    logic          hit_reg;
    logic          full_reg;
    logic [63:0]   kmask;
    logic [63:0]   vmask;
    logic [9:0]    rem_sh;
    logic [7:0]    kbyte;

    assign kmask = byte_mask(nk_c);
    assign vmask = byte_mask(nv_c);
    assign req_stall = (state_reg != S_IDLE) || rsp_valid;
    assign kbyte = key_reg[8*cnt_reg[2:0] +: 8];
    assign rem_sh = {rem_reg, hash_reg[63]};

    always_comb
    begin
        hd_we    = 1'b0;
        hd_addr  = bkt_reg;
        hd_wdata = '0;
        en_we    = 1'b0;
        en_addr  = cur_reg;
        en_wdata = {key_reg & kmask, data_reg & vmask};
        ln_we    = 1'b0;
        ln_wdata = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                hd_we   = 1'b1;
                hd_addr = clr_reg[BW-1:0];
            end
            S_HEAD:  hd_addr = rem_reg[BW-1:0];
            S_ENT:   en_addr = head_reg[PW-1:0];
            S_WRITE:
            begin
                if (req_reg == REQ_INSERT && hit_reg)
                begin
                    en_we = 1'b1;
                    en_wdata = {en_rdata[127:64], data_reg & vmask};
                end
                else if (req_reg == REQ_INSERT)
                begin
                    en_we    = 1'b1;
                    en_addr  = slot_reg;
                    ln_we    = 1'b1;
                    ln_wdata = head_reg;
                    hd_we    = 1'b1;
                    hd_wdata = {1'b1, slot_reg};
                end
                else if (have_prev_reg)
                begin
                    ln_we    = 1'b1;
                    en_addr  = prev_reg;
                    ln_wdata = succ_reg;
                end
                else
                begin
                    hd_we    = 1'b1;
                    hd_wdata = succ_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            nbuck_reg     <= 9'd64;
            nkey_reg      <= 4'd8;
            nval_reg      <= 4'd8;
            free_reg      <= '1;
            live_reg      <= '0;
            clr_reg       <= '0;
            rsp_valid     <= 1'b0;
            hit_reg       <= 1'b0;
            full_reg      <= 1'b0;
            have_prev_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                unique case (paddr[3:2])
                    REG_BUCKETS: nbuck_reg <= pwdata[8:0];
                    REG_KEY_LEN: nkey_reg  <= pwdata[3:0];
                    REG_VAL_LEN: nval_reg  <= pwdata[3:0];
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (BW+1)'(MAX_BUCKETS - 1)) state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (req_valid && !rsp_valid)
                    begin
                        req_reg       <= req_type;
                        key_reg       <= lookup_key;
                        data_reg      <= data_value;
                        hash_reg      <= HASH_SEED;
                        cnt_reg       <= '0;
                        hit_reg       <= 1'b0;
                        full_reg      <= 1'b0;
                        have_prev_reg <= 1'b0;
                        state_reg     <= S_HASH;
                    end
                end
                S_HASH:
                begin
                    hash_reg <= (hash_reg << HASH_SHIFT) + hash_reg + {56'd0, kbyte};
                    cnt_reg  <= cnt_reg + 1'b1;
                    if (cnt_reg + 1'b1 == nk_c)
                    begin
                        bit_reg   <= '0;
                        rem_reg   <= '0;
                        state_reg <= S_MOD;
                    end
                end
                S_MOD:
                begin
                    // restoring remainder, one hash bit per cycle
                    hash_reg <= hash_reg << 1;
                    rem_reg  <= (rem_sh >= {1'b0, nb_c}) ? 9'(rem_sh - {1'b0, nb_c})
                                                         : rem_sh[8:0];
                    bit_reg  <= bit_reg + 1'b1;
                    if (bit_reg == 7'd63) state_reg <= S_HEAD;
                end
                S_HEAD:
                begin
                    bkt_reg   <= rem_reg[BW-1:0];
                    steps_reg <= '0;
                    state_reg <= S_HEADW;
                end
                S_HEADW:
                begin
                    head_reg  <= hd_rdata;
                    state_reg <= hd_rdata[PW] ? S_ENT : S_FREE;
                    cur_reg   <= hd_rdata[PW-1:0];
                    if (!hd_rdata[PW]) slot_reg <= '0;
                end
                S_ENT:
                begin
                    cur_reg   <= head_reg[PW-1:0];
                    state_reg <= S_ENTW;
                end
                S_ENTW:
                begin
                    if (((en_rdata[127:64] ^ key_reg) & kmask) == 64'd0)
                    begin
                        hit_reg   <= 1'b1;
                        succ_reg  <= ln_rdata;
                        state_reg <= S_WRITE;
                        priority if (req_reg == REQ_GET)
                            value_out <= en_rdata[63:0] & vmask;
                        else
                            value_out <= '0;
                        if (req_reg == REQ_GET || req_reg == REQ_CONTAINS)
                            state_reg <= S_DONE;
                    end
                    else if (!ln_rdata[PW] || steps_reg == CW'(POOL_ENTRIES - 1))
                    begin
                        head_reg  <= {1'b1, cur_reg};
                        slot_reg  <= '0;
                        state_reg <= S_FREE;
                    end
                    else
                    begin
                        have_prev_reg <= 1'b1;
                        prev_reg      <= cur_reg;
                        head_reg      <= ln_rdata;
                        steps_reg     <= steps_reg + 1'b1;
                        state_reg     <= S_ENT;
                    end
                end
                S_FREE:
                begin
                    // miss: only an insert goes on to claim a slot
                    value_out <= '0;
                    if (req_reg != REQ_INSERT)
                    begin
                        state_reg <= S_DONE;
                    end
                    else if (free_reg[slot_reg])
                    begin
                        state_reg <= S_FREEW;
                    end
                    else if (slot_reg == PW'(POOL_ENTRIES - 1))
                    begin
                        full_reg  <= 1'b1;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        slot_reg <= slot_reg + 1'b1;
                    end
                end
                S_FREEW:
                begin
                    // reread the real head: head_reg was walked along the chain during the key search
                    state_reg <= S_WRITE2;
                end
                S_WRITE2:
                begin
                    head_reg  <= hd_rdata;
                    state_reg <= S_WRITE;
                end
                S_WRITE:
                begin
                    if (req_reg == REQ_INSERT && !hit_reg)
                    begin
                        free_reg[slot_reg] <= 1'b0;
                        live_reg <= live_reg + 1'b1;
                    end
                    else if (req_reg == REQ_REMOVE)
                    begin
                        free_reg[cur_reg] <= 1'b1;
                        if (live_reg != 9'd0) live_reg <= live_reg - 1'b1;
                    end
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!rsp_valid)
                    begin
                        rsp_valid <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
            if (rsp_valid && !rsp_stall)
            begin
                rsp_valid <= 1'b0;
            end
        end
    end

    // status and total follow the result register
    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE && !rsp_valid)
        begin
            found       <= hit_reg;
            entry_total <= live_reg;
            if (hit_reg)
                status <= ST_OK;
            else if (req_reg == REQ_INSERT)
                status <= full_reg ? ST_FULL : ST_OK;
            else
                status <= ST_NOT_FOUND;
        end
    end
endmodule
`default_nettype wire

FILE: bench/tb_chained_hash_table_engine_unit.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_chained_hash_table_engine_unit
// self-checking bench for the chained hash table engine: a queue-fed driver
// sends requests with random gaps, a monitor predicts each response from a
// behavioral copy of the table and compares it field by field. the run
// steps through several bucket/key/value settings, including the clamped
// extremes, and fills the entry pool to overflow before draining it.
// ---------------------------------------------------------------------------
module tb_chained_hash_table_engine_unit;
    import chte_pkg::*;

    localparam int POOL      = 256;
    localparam int NBUCKETS  = 256;
    localparam int WDOG_MAX  = 20000;

    typedef struct {
        logic [1:0]  kind;
        logic [63:0] key;
        logic [63:0] data;
        bit          hold;
    } table_req_t;

    typedef struct {
        logic [1:0]  st;
        logic        hit;
        logic [63:0] value;
        logic [8:0]  total;
    } table_rsp_t;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    logic [1:0]  req_type;
    logic [63:0] lookup_key;
    logic [63:0] data_value;
    logic        rsp_valid;
    logic        rsp_stall;
    logic [1:0]  status;
    logic        found;
    logic [63:0] value_out;
    logic [8:0]  entry_total;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    chained_hash_table_engine_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_type    (req_type),
        .lookup_key  (lookup_key),
        .data_value  (data_value),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .status      (status),
        .found       (found),
        .value_out   (value_out),
        .entry_total (entry_total),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // shadow table
    logic [8:0]  cfg_buckets;
    logic [3:0]  cfg_key_len;
    logic [3:0]  cfg_val_len;
    logic [8:0]  sh_head   [NBUCKETS];
    bit          sh_hvalid [NBUCKETS];
    logic [63:0] sh_key    [POOL];
    logic [63:0] sh_val    [POOL];
    logic [8:0]  sh_link   [POOL];
    bit          sh_lvalid [POOL];
    bit          sh_free   [POOL];
    int          sh_live;

    table_req_t  pending_reqs[$];
    table_rsp_t  expected_rsps[$];
    logic [63:0] key_pool[$];

    int  errors;
    int  wdog;
    int  gap_left;
    int  stall_left;
    bit  no_idle;
    bit  req_fire;
    int  n_sent;
    int  n_full;
    int  n_hits;

    function automatic logic [63:0] mask_bytes(input logic [3:0] n);
        logic [63:0] m;
        m = '1;
        if (n < 8)
        begin
            m = (64'd1 << (n * 8)) - 64'd1;
        end
        return m;
    endfunction

    function automatic table_rsp_t table_apply(input table_req_t r);
        table_rsp_t  o;
        int          nb;
        logic [3:0]  nk;
        logic [3:0]  nv;
        logic [63:0] km;
        logic [63:0] h;
        int          b;
        bit          have;
        int          cur;
        bit          have_prev;
        int          prev;
        int          s;
        nb = (cfg_buckets == 0) ? 1 : (cfg_buckets > NBUCKETS ? NBUCKETS : cfg_buckets);
        nk = (cfg_key_len == 0) ? 4'd1 : (cfg_key_len > 8 ? 4'd8 : cfg_key_len);
        nv = (cfg_val_len == 0) ? 4'd1 : (cfg_val_len > 8 ? 4'd8 : cfg_val_len);
        km = mask_bytes(nk);
        h = HASH_SEED;
        for (int i = 0; i < nk; i++)
        begin
            h = (h << HASH_SHIFT) + h + {56'd0, r.key[8*i +: 8]};
        end
        b = int'(h % 64'(nb));
        have = sh_hvalid[b];
        cur = sh_head[b];
        have_prev = 0;
        prev = 0;
        o.st = ST_OK;
        o.hit = 0;
        o.value = '0;
        for (int k = 0; have && k < POOL; k++)
        begin
            if (((sh_key[cur] ^ r.key) & km) == 0)
            begin
                o.hit = 1;
                break;
            end
            have_prev = 1;
            prev = cur;
            have = sh_lvalid[cur];
            cur = sh_link[cur];
        end
        case (r.kind)
            REQ_INSERT:
            begin
                if (o.hit)
                begin
                    sh_val[cur] = r.data & mask_bytes(nv);
                end
                else
                begin
                    for (s = 0; s < POOL && !sh_free[s]; s++)
                    begin
                    end
                    if (s >= POOL)
                    begin
                        o.st = ST_FULL;
                    end
                    else
                    begin
                        sh_free[s] = 0;
                        sh_key[s] = r.key & km;
                        sh_val[s] = r.data & mask_bytes(nv);
                        sh_link[s] = sh_head[b];
                        sh_lvalid[s] = sh_hvalid[b];
                        sh_head[b] = 9'(s);
                        sh_hvalid[b] = 1;
                        sh_live++;
                    end
                end
            end
            REQ_GET:
            begin
                if (o.hit)
                    o.value = sh_val[cur] & mask_bytes(nv);
                else
                    o.st = ST_NOT_FOUND;
            end
            REQ_REMOVE:
            begin
                if (o.hit)
                begin
                    if (have_prev)
                    begin
                        sh_link[prev] = sh_link[cur];
                        sh_lvalid[prev] = sh_lvalid[cur];
                    end
                    else
                    begin
                        sh_head[b] = sh_link[cur];
                        sh_hvalid[b] = sh_lvalid[cur];
                    end
                    sh_free[cur] = 1;
                    sh_lvalid[cur] = 0;
                    if (sh_live > 0)
                        sh_live--;
                end
                else
                begin
                    o.st = ST_NOT_FOUND;
                end
            end
            default:
            begin
                if (!o.hit)
                    o.st = ST_NOT_FOUND;
            end
        endcase
        o.total = 9'(sh_live);
        return o;
    endfunction

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // monitor: acceptance, prediction, checking, watchdog
    always @(posedge clk)
    begin
        table_rsp_t e;
        bit         moved;
        bit         fired;
        moved = 0;
        fired = 0;
        if (rst_n && req_valid && !req_stall)
        begin
            table_req_t r;
            r.kind = req_type;
            r.key = lookup_key;
            r.data = data_value;
            r.hold = 0;
            e = table_apply(r);
            if (e.st == ST_FULL)
                n_full++;
            if (e.hit)
                n_hits++;
            expected_rsps.push_back(e);
            fired = 1;
            moved = 1;
        end
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            moved = 1;
            if (expected_rsps.size() == 0)
            begin
                $error("unexpected response beat");
                errors++;
            end
            else
            begin
                e = expected_rsps.pop_front();
                if (status !== e.st)
                begin
                    $error("status exp %0d got %0d", e.st, status);
                    errors++;
                end
                if (found !== e.hit)
                begin
                    $error("found exp %0d got %0d", e.hit, found);
                    errors++;
                end
                if (value_out !== e.value)
                begin
                    $error("value_out exp %h got %h", e.value, value_out);
                    errors++;
                end
                if (entry_total !== e.total)
                begin
                    $error("entry_total exp %0d got %0d", e.total, entry_total);
                    errors++;
                end
            end
        end
        if (psel)
            moved = 1;
        req_fire <= fired;
        wdog <= moved ? 0 : wdog + 1;
        if (wdog >= WDOG_MAX)
        begin
            $display("watchdog expired with %0d requests and %0d responses outstanding",
                     pending_reqs.size(), expected_rsps.size());
            $display("tb_chained_hash_table_engine_unit: errors");
            $finish;
        end
    end

    function automatic int pick_gap();
        if (no_idle)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(0, 2);
        return $urandom_range(5, 40);
    endfunction

    // driver: request side
    always @(negedge clk)
    begin
        if (rst_n && (!req_valid || req_fire))
        begin
            if (gap_left > 0)
            begin
                req_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_reqs.size() != 0 &&
                     !(pending_reqs[0].hold && expected_rsps.size() != 0))
            begin
                table_req_t r;
                r = pending_reqs.pop_front();
                req_valid <= 1'b1;
                req_type <= r.kind;
                lookup_key <= r.key;
                data_value <= r.data;
                n_sent++;
                gap_left <= pick_gap();
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    // response side backpressure, runs of stall cycles
    always @(negedge clk)
    begin
        if (no_idle)
        begin
            rsp_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            rsp_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 9) < 7)
        begin
            rsp_stall <= 1'b0;
        end
        else
        begin
            rsp_stall <= 1'b1;
            stall_left <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                     : $urandom_range(5, 40);
        end
    end

    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            REG_BUCKETS: cfg_buckets = val[8:0];
            REG_KEY_LEN: cfg_key_len = val[3:0];
            default:     cfg_val_len = val[3:0];
        endcase
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_config(input int nb, input int nk, input int nv);
        cfg_write(REG_BUCKETS, 32'(nb));
        cfg_write(REG_KEY_LEN, 32'(nk));
        cfg_write(REG_VAL_LEN, 32'(nv));
    endtask

    task automatic add_req(input logic [1:0] k, input logic [63:0] key,
                           input logic [63:0] data, input bit hold);
        table_req_t r;
        r.kind = k;
        r.key = key;
        r.data = data;
        r.hold = hold;
        pending_reqs.push_back(r);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic drain();
        while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || req_valid)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // mostly keys from a small working set, sometimes with upper bytes flipped
    task automatic random_phase(input int count);
        logic [63:0] k;
        key_pool.delete();
        for (int i = 0; i < 24; i++)
            key_pool.push_back(rand64());
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 9))
                0, 1:    k = rand64();
                2:       k = key_pool[$urandom_range(0, 23)] ^ (rand64() << 8 * $urandom_range(1, 7));
                default: k = key_pool[$urandom_range(0, 23)];
            endcase
            add_req(2'($urandom_range(0, 3)), k, rand64(), i == count / 2);
        end
        drain();
    endtask

    initial
    begin
        errors = 0;
        wdog = 0;
        gap_left = 0;
        stall_left = 0;
        no_idle = 0;
        req_fire = 0;
        n_sent = 0;
        n_full = 0;
        n_hits = 0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_type = REQ_INSERT;
        lookup_key = '0;
        data_value = '0;
        rsp_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cfg_buckets = 9'd64;
        cfg_key_len = 4'd8;
        cfg_val_len = 4'd8;
        for (int i = 0; i < NBUCKETS; i++)
        begin
            sh_head[i] = '0;
            sh_hvalid[i] = 0;
        end
        for (int i = 0; i < POOL; i++)
        begin
            sh_key[i] = '0;
            sh_val[i] = '0;
            sh_link[i] = '0;
            sh_lvalid[i] = 0;
            sh_free[i] = 1;
        end
        sh_live = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed, reset settings
        add_req(REQ_GET, '0, '0, 0);
        add_req(REQ_INSERT, '0, '1, 0);
        add_req(REQ_INSERT, '1, 64'h0123_4567_89ab_cdef, 0);
        add_req(REQ_GET, '0, '0, 0);
        add_req(REQ_GET, '1, '0, 0);
        add_req(REQ_CONTAINS, '1, '1, 0);
        add_req(REQ_CONTAINS, 64'h5555_5555_5555_5555, '0, 0);
        add_req(REQ_INSERT, '1, 64'hffff_0000_ffff_0000, 0);
        add_req(REQ_GET, '1, '0, 0);
        add_req(REQ_REMOVE, 64'haaaa_aaaa_aaaa_aaaa, '0, 0);
        add_req(REQ_REMOVE, '0, '1, 0);
        add_req(REQ_GET, '0, '0, 0);
        add_req(REQ_INSERT, 64'h8000_0000_0000_0001, '1, 1);
        drain();
        // value width shrinks after storing; key compare on low bytes only
        set_config(7, 3, 2);
        add_req(REQ_GET, 64'h8000_0000_0000_0001, '0, 0);
        add_req(REQ_INSERT, 64'h0000_0000_00c0_ffee, '1, 0);
        add_req(REQ_GET, 64'hdead_beef_00c0_ffee, '0, 0);
        add_req(REQ_CONTAINS, 64'h1234_5678_00c0_ffee, '0, 0);
        add_req(REQ_REMOVE, 64'hffff_ffff_ffc0_ffee, '0, 0);
        add_req(REQ_GET, '1, '0, 0);
        drain();

        no_idle = 1;
        random_phase(120);
        no_idle = 0;
        set_config(0, 0, 0);
        random_phase(180);
        set_config(511, 15, 15);
        random_phase(180);
        set_config(1, 8, 8);
        random_phase(150);
        set_config(256, 1, 1);
        random_phase(180);

        // fill the pool past capacity, then empty it again
        set_config(256, 8, 8);
        key_pool.delete();
        for (int i = 0; i < POOL + 8; i++)
        begin
            key_pool.push_back({$urandom(), 24'(i), 8'hff});
            add_req(REQ_INSERT, key_pool[i], rand64(), 0);
        end
        add_req(REQ_GET, key_pool[3], '0, 1);
        for (int i = 0; i < POOL + 8; i++)
            add_req(REQ_REMOVE, key_pool[i], '0, 0);
        drain();

        set_config(13, 4, 6);
        random_phase(200);
        set_config(2, 2, 3);
        random_phase(150);
        set_config(64, 8, 8);
        random_phase(150);
        repeat (50) @(posedge clk);

        $display("%0d requests sent over 10 settings, %0d hits, %0d pool-full responses",
                 n_sent, n_hits, n_full);
        if (errors == 0 && expected_rsps.size() == 0)
        begin
            $display("tb_chained_hash_table_engine_unit: clean");
        end
        else
        begin
            $display("tb_chained_hash_table_engine_unit: errors");
        end
        $finish;
    end

endmodule
